[design/kwsc_pkg.sv]
`default_nettype none

package kwsc_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OpClear  = 2'd0,
    OpKey    = 2'd1,
    OpFinish = 2'd2,
    OpText   = 2'd3
  } opcode_e;

  // result status codes
  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusNonLetter = 2'd1,
    StatusNotReady  = 2'd2
  } status_e;

  // ascii code of the first letter
  localparam logic [7:0] LetterBase = 8'd65;

  // depth of the queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // classified item handed from front to back
  typedef struct packed {
    opcode_e    op;
    logic [7:0] sym;
    logic       letter;
  } kwsc_item_t;

endpackage

`default_nettype wire

[design/keyword_substitution_cipher_top.sv]
`default_nettype none

// Keyword substitution cipher over the uppercase letters starting at 'A'.
// Items carry an opcode (clear key, key letter, finish table, text byte) and
// a byte. The front classifies each item and places it in a two-entry queue,
// so the input takes one item per cycle while the queue has room; the back
// executes items one at a time. Clear, key and pass-through text items are
// done as they are taken; a text letter goes through a registered table read,
// then into the result register once that is free. A finish item walks the
// table slots from the key length up, scanning letters downward from the
// highest, until every slot is filled. Only text items give a result, held in
// an output register until taken. Setting direction to 1 selects the decrypt
// table; write it only while the block is idle.

module keyword_substitution_cipher_top
  import kwsc_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] symbol_i,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_symbol_o,
  output logic [1:0] status_o
);

  logic       q_full, push, head_valid, pop;
  kwsc_item_t push_item, head;

  // classify incoming items
  kwsc_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .symbol_i   (symbol_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_item_o(push_item)
  );

  // decoupling queue
  kwsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // key state, tables and result register
  kwsc_back #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_symbol_o(out_symbol_o),
    .status_o    (status_o)
  );

endmodule

`default_nettype wire

[design/kwsc_front.sv]
`default_nettype none

module kwsc_front
  import kwsc_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] symbol_i,
  input  logic       q_full_i,
  output logic       push_o,
  output kwsc_item_t push_item_o
);

  localparam logic [7:0] LetterEnd = LetterBase + 8'(ALPHABET_SIZE);

  // stall whenever the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the byte as a letter of the alphabet or not
  always_comb begin
    push_item_o.op     = opcode_e'(opcode_i);
    push_item_o.sym    = symbol_i;
    push_item_o.letter = (symbol_i >= LetterBase) && (symbol_i < LetterEnd);
  end

endmodule

`default_nettype wire

[design/kwsc_queue.sv]
`default_nettype none

module kwsc_queue
  import kwsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  kwsc_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output kwsc_item_t head_o
);

  kwsc_item_t             entries_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o       = (count_q == (QueuePtrW + 1)'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  property p_no_overflow;
    @(posedge clk_i) disable iff (!rst_ni)
      count_q <= (QueuePtrW + 1)'(QueueDepth);
  endproperty
  a_no_overflow: assert property (p_no_overflow) else $error("queue count overflow");

  property p_pop_moves_ptr;
    @(posedge clk_i) disable iff (!rst_ni)
      do_pop |=> (rd_ptr_q == $past(rd_ptr_q) + 1'b1);
  endproperty
  a_pop_moves_ptr: assert property (p_pop_moves_ptr) else $error("read pointer stuck");

  property p_count_tracks;
    @(posedge clk_i) disable iff (!rst_ni)
      (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1);
  endproperty
  a_count_tracks: assert property (p_count_tracks) else $error("count not updated on push");

endmodule

`default_nettype wire

[design/kwsc_back.sv]
`default_nettype none

module kwsc_back
  import kwsc_pkg::*;
#(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  kwsc_item_t head_i,
  output logic       pop_o,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_symbol_o,
  output logic [1:0] status_o
);

  localparam int IdxW = $clog2(ALPHABET_SIZE);
  localparam int CntW = $clog2(ALPHABET_SIZE + 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(ALPHABET_SIZE);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(ALPHABET_SIZE - 1);

  // sequencer states
  localparam logic [1:0] SRun  = 2'd0;
  localparam logic [1:0] SFill = 2'd1;
  localparam logic [1:0] SLook = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [ALPHABET_SIZE-1:0] used_q, used_d;
  logic [CntW-1:0]          key_count_q, key_count_d;
  logic                     ready_q, ready_d;
  logic [CntW-1:0]          slot_q, slot_d;
  logic [IdxW-1:0]          fill_q, fill_d;
  logic                     dir_q;
  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_sym_q, out_sym_d;
  status_e                  status_q, status_d;

  logic [IdxW-1:0] fwd_mem [ALPHABET_SIZE];
  logic [IdxW-1:0] inv_mem [ALPHABET_SIZE];
  logic [IdxW-1:0] fwd_rd_q, inv_rd_q;

  logic [IdxW-1:0] idx;
  logic [7:0]      idx_full;
  logic            out_free, is_lookup, key_add, rd_en, out_load;
  logic            mem_we;
  logic [IdxW-1:0] wr_slot, wr_letter;

  // letter index of the head byte
  assign idx_full = head_i.sym - LetterBase;
  assign idx      = idx_full[IdxW-1:0];

  assign out_free  = !out_valid_q || !out_stall_i;
  assign is_lookup = (head_i.op == OpText) && ready_q && head_i.letter;

  // in the run state, take the head item unless a pass-through result has nowhere to go
  always_comb begin
    pop_o = 1'b0;
    case (state_q)
      SRun: begin
        if (head_valid_i && (head_i.op != OpText || is_lookup || out_free)) begin
          pop_o = 1'b1;
        end
      end
      default: pop_o = 1'b0;
    endcase
  end

  assign key_add = pop_o && (head_i.op == OpKey) && head_i.letter && !used_q[idx]
                   && (key_count_q < CntFull);
  assign rd_en   = pop_o && is_lookup;

  // sequencer and key state
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    key_count_d = key_count_q;
    ready_d     = ready_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    out_load    = 1'b0;
    out_sym_d   = head_i.sym;
    status_d    = StatusOk;
    mem_we      = 1'b0;
    case (state_q)
      SRun: begin
        if (pop_o) begin
          case (head_i.op)
            OpClear: begin
              used_d      = '0;
              key_count_d = '0;
              ready_d     = 1'b0;
            end
            OpKey: begin
              if (key_add) begin
                used_d[idx] = 1'b1;
                key_count_d = key_count_q + 1'b1;
                ready_d     = 1'b0;
                mem_we      = 1'b1;
              end
            end
            OpFinish: begin
              slot_d  = key_count_q;
              fill_d  = LastIdx;
              state_d = SFill;
            end
            default: begin
              if (is_lookup) begin
                state_d = SLook;
              end else begin
                out_load = 1'b1;
                status_d = ready_q ? StatusNonLetter : StatusNotReady;
              end
            end
          endcase
        end
      end
      SFill: begin
        // walk down from the highest letter, filling free slots
        if (slot_q == CntFull) begin
          ready_d = 1'b1;
          state_d = SRun;
        end else begin
          if (!used_q[fill_q]) begin
            mem_we = 1'b1;
            slot_d = slot_q + 1'b1;
          end
          fill_d = fill_q - 1'b1;
        end
      end
      SLook: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_sym_d = LetterBase + 8'(dir_q ? inv_rd_q : fwd_rd_q);
          status_d  = StatusOk;
          state_d   = SRun;
        end
      end
      default: state_d = SRun;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SRun;
      used_q      <= '0;
      key_count_q <= '0;
      ready_q     <= 1'b0;
      slot_q      <= '0;
      fill_q      <= '0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      key_count_q <= key_count_d;
      ready_q     <= ready_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sym_q <= out_sym_d;
      status_q  <= status_d;
    end
  end

  // table writes: forward[slot] = letter and inverse[letter] = slot
  assign wr_slot   = (state_q == SFill) ? slot_q[IdxW-1:0] : key_count_q[IdxW-1:0];
  assign wr_letter = (state_q == SFill) ? fill_q : idx;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fwd_mem[wr_slot] <= wr_letter;
    end
    if (rd_en) begin
      fwd_rd_q <= fwd_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      inv_mem[wr_letter] <= wr_slot;
    end
    if (rd_en) begin
      inv_rd_q <= inv_mem[idx];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign status_o     = status_q;

  property p_count_matches_used;
    @(posedge clk_i) disable iff (!rst_ni)
      $countones(used_q) == int'(key_count_q);
  endproperty
  a_count_matches_used: assert property (p_count_matches_used)
    else $error("key count differs from used letters");

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      key_count_q <= CntFull;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("key count beyond alphabet");

  property p_busy_no_pop;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q != SRun) |-> !pop_o;
  endproperty
  a_busy_no_pop: assert property (p_busy_no_pop) else $error("item taken while busy");

  property p_key_clears_ready;
    @(posedge clk_i) disable iff (!rst_ni)
      key_add |=> !ready_q;
  endproperty
  a_key_clears_ready: assert property (p_key_clears_ready)
    else $error("table still ready after key change");

endmodule

`default_nettype wire
